@@ src/cir_pkg.sv @@
// Package: shared constants, types and CRC function for the chunked image receiver.
package cir_pkg;
  localparam int PAGE_BYTES_DEF = 128;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam logic [31:0] FLASH_BASE_RST = 32'd4194304;
  localparam logic [31:0] MAGIC_RST = 32'h4788CAFE;
  localparam logic [31:0] MIN_RST = 32'd512;
  localparam logic [31:0] MAX_RST = 32'd4194304;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_MAGIC = 2'd1;
  localparam logic [1:0] REG_MIN = 2'd2;
  localparam logic [1:0] REG_MAX = 2'd3;

  localparam logic [1:0] K_ERASE = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_PEND = 2'd2;
  localparam logic [1:0] K_RESP = 2'd3;

  localparam logic [2:0] RC_OK = 3'd0;
  localparam logic [2:0] RC_SIG = 3'd1;
  localparam logic [2:0] RC_ILEN = 3'd2;
  localparam logic [2:0] RC_CLEN = 3'd3;
  localparam logic [2:0] RC_CRC = 3'd4;
  localparam logic [2:0] RC_SUM = 3'd5;
  localparam logic [2:0] RC_OFS = 3'd6;
  localparam logic [2:0] RC_VER = 3'd7;

  typedef struct packed {
    logic [0:0] req_type;
    logic [7:0] rx_byte;
    logic [0:0] verify_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] flash_address;
    logic [31:0] write_word;
    logic [7:0]  page_bytes_written;
    logic [2:0]  resp_code;
    logic [15:0] resp_crc;
    logic [0:0]  last;
  } out_item_t;

  // command from controller to datapath
  typedef enum logic [3:0] {
    C_NONE, C_BYTE, C_VERIFY, C_FIN_START, C_ERASE, C_WORD, C_PEND, C_RESP,
    C_TAIL_MAGIC, C_TAIL_SIZE, C_TAIL_SUM
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] code;
    logic       last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       byte_done;   // last byte handled, flags below valid
    logic       fail;
    logic [2:0] fail_code;
    logic       finish;      // chunk complete, emit pages
    logic       first;
    logic       erase_due;
    logic       word_more;   // another page word remains
    logic       done_img;    // image complete after verify ok
    logic       sum_ok;
  } stat_t;

  function automatic logic [15:0] crc8(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction
endpackage

@@ src/cir_if.sv @@
// Interface: valid/ready channel carrying one item.
interface cir_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/cir_datapath.sv @@
// Datapath: field parsing, CRC, sums, page store and result formatting.
module cir_datapath #(
  parameter int PAGE_BYTES = cir_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = cir_pkg::SECTOR_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_data,
  input  cir_pkg::in_item_t item,
  input  cir_pkg::cmd_t    cmd,
  output cir_pkg::stat_t   stat,
  output cir_pkg::out_item_t res
);
  import cir_pkg::*;
  localparam int PW = PAGE_BYTES / 4;
  localparam int WIW = $clog2(PW + 1);
  localparam int AW = $clog2(PW);
  localparam int SB = $clog2(SECTOR_BYTES);
  localparam logic [3:0] PH_OFS = 4'd0, PH_LEN = 4'd1, PH_CRC = 4'd2, PH_SIG = 4'd3,
                         PH_SIZE = 4'd4, PH_SUM = 4'd5, PH_DATA = 4'd6;

  logic [31:0] flash_base, image_magic, min_b, max_b;
  logic [3:0]  phase;
  logic [2:0]  fcnt;
  logic [31:0] wsh, chunk_offset, prev_offset, image_size, sum_exp, data_sum;
  logic [31:0] bytes_done, write_address, erased_sector, base, fin_addr;
  logic [15:0] chunk_len, crc_exp, crc_run;
  logic [WIW-1:0] word_index, rd_i, nw;
  logic        first_chunk;
  logic [31:0] page_store [PW];
  logic [31:0] rd_data;

  logic [31:0] sh_n;
  logic [2:0]  fcnt_n;
  logic        full4, full2;
  logic [15:0] crc_n;
  logic [WIW-1:0] wi_n;
  logic [WIW-1:0] nw_len;
  logic [WIW-1:0] rd_next;

  assign sh_n = {item.rx_byte, wsh[31:8]};
  assign fcnt_n = fcnt + 3'd1;
  assign full4 = (fcnt_n == 3'd4);
  assign full2 = (fcnt_n == 3'd2);
  assign crc_n = crc8(crc_run, item.rx_byte);
  assign wi_n = word_index + WIW'(1);
  assign nw_len = (chunk_len[15:2] > 14'(PW)) ? WIW'(PW) : WIW'(chunk_len[15:2]);

  // parse step: combinational flags for one byte
  logic pf; logic [2:0] pcode; logic pfin;
  always_comb begin
    pf = 1'b0; pcode = RC_OK; pfin = 1'b0;
    unique case (phase)
      PH_OFS: if (full4 && (first_chunk ? (sh_n != 0) : (sh_n <= prev_offset))) begin
        pf = 1'b1; pcode = RC_OFS;
      end
      PH_LEN: if (full2 && (first_chunk ? (sh_n[31:16] != 16'(PAGE_BYTES))
                  : (sh_n[31:16] > 16'(PAGE_BYTES) || sh_n[17:16] != 2'd0))) begin
        pf = 1'b1; pcode = RC_CLEN;
      end
      PH_CRC: if (full2 && !first_chunk && chunk_len[15:2] == 14'd0) pfin = 1'b1;
      PH_SIG: if (full4 && sh_n != image_magic) begin pf = 1'b1; pcode = RC_SIG; end
      PH_SIZE: if (full4 && (sh_n < min_b || sh_n > max_b)) begin
        pf = 1'b1; pcode = RC_ILEN;
      end
      PH_SUM: if (full4) begin
        if (sh_n == 0) begin pf = 1'b1; pcode = RC_SUM; end
        else if (nw_len <= WIW'(3)) pfin = 1'b1;
      end
      PH_DATA: if (full4 && (wi_n >= nw_len)) pfin = 1'b1;
      default: ;
    endcase
  end

  logic [31:0] ws_base;
  assign ws_base = write_address - (write_address & 32'(SECTOR_BYTES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= FLASH_BASE_RST; image_magic <= MAGIC_RST;
      min_b <= MIN_RST; max_b <= MAX_RST;
      phase <= PH_OFS; fcnt <= '0; wsh <= '0; chunk_offset <= '0; prev_offset <= '0;
      chunk_len <= '0; crc_exp <= '0; crc_run <= CRC_INIT; word_index <= '0;
      image_size <= '0; sum_exp <= '0; data_sum <= '0; bytes_done <= '0;
      write_address <= '0; erased_sector <= '0; first_chunk <= 1'b1;
      stat <= '0; res <= '0; rd_i <= '0; base <= '0; fin_addr <= '0; nw <= '0;
    end else begin
      stat.byte_done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BASE: flash_base <= cfg_data;
          REG_MAGIC: image_magic <= cfg_data;
          REG_MIN: min_b <= cfg_data;
          REG_MAX: max_b <= cfg_data;
        endcase
      end
      unique case (cmd.op)
        C_BYTE: begin
          stat.byte_done <= 1'b1;
          stat.fail <= pf; stat.fail_code <= pcode; stat.finish <= 1'b0;
          stat.first <= first_chunk;
          if (phase >= PH_SIG) crc_run <= crc_n;
          if (phase == PH_LEN || phase == PH_CRC) fcnt <= full2 ? '0 : fcnt_n;
          else fcnt <= full4 ? '0 : fcnt_n;
          wsh <= sh_n;
          unique case (phase)
            PH_OFS: if (full4) begin chunk_offset <= sh_n; phase <= PH_LEN; end
            PH_LEN: if (full2) begin
              chunk_len <= sh_n[31:16]; prev_offset <= chunk_offset; phase <= PH_CRC;
            end
            PH_CRC: if (full2) begin
              crc_exp <= sh_n[31:16]; crc_run <= CRC_INIT; word_index <= '0;
              phase <= first_chunk ? PH_SIG : PH_DATA;
              if (pfin) begin stat.finish <= 1'b1; stat.fail <= 1'b0; end
            end
            PH_SIG: if (full4) phase <= PH_SIZE;
            PH_SIZE: if (full4) begin image_size <= sh_n; phase <= PH_SUM; end
            PH_SUM: if (full4) begin
              sum_exp <= sh_n; word_index <= WIW'(3); phase <= PH_DATA;
              stat.finish <= pfin;
            end
            PH_DATA: if (full4) begin
              page_store[word_index[AW-1:0]] <= sh_n;
              data_sum <= data_sum + sh_n; word_index <= wi_n;
              stat.finish <= pfin;
            end
            default: ;
          endcase
          // crc compare happens at finish start
        end
        C_FIN_START: begin
          stat.fail <= (crc_run != crc_exp); stat.fail_code <= RC_CRC;
          stat.erase_due <= first_chunk ||
            ({1'b0, write_address} >= {1'b0, erased_sector} + 33'(SECTOR_BYTES));
          nw <= nw_len;
          rd_i <= first_chunk ? WIW'(3) : '0;
          base <= first_chunk ? flash_base + 32'd12 : write_address;
          fin_addr <= first_chunk ? flash_base + 32'd12 : write_address;
          stat.word_more <= first_chunk ? (nw_len > WIW'(3)) : (nw_len != '0);
        end
        C_ERASE: begin
          erased_sector <= first_chunk ?
            {flash_base[31:SB], SB'(0)} : ws_base;
          res <= '{K_ERASE, first_chunk ? {flash_base[31:SB], SB'(0)} : ws_base,
                   32'd0, 8'd0, RC_OK, 16'd0, cmd.last};
        end
        C_WORD: begin
          res <= '{K_WRITE, fin_addr, rd_data, 8'd0, RC_OK, 16'd0, cmd.last};
          fin_addr <= fin_addr + 32'd4;
          rd_i <= rd_i + WIW'(1);
          stat.word_more <= (rd_i + WIW'(1)) < nw;
        end
        C_PEND: begin
          res <= '{K_PEND, base, 32'd0,
                   first_chunk ? ((nw > WIW'(3)) ? 8'(4 * (nw - WIW'(3))) : 8'd0)
                               : 8'(4 * nw),
                   RC_OK, 16'd0, cmd.last};
          phase <= PH_OFS;
        end
        C_VERIFY: begin
          if (first_chunk) begin
            first_chunk <= 1'b0;
            bytes_done <= 32'(PAGE_BYTES - 12);
            write_address <= flash_base + 32'(PAGE_BYTES);
            stat.done_img <= 32'(PAGE_BYTES - 12) >= image_size;
          end else begin
            bytes_done <= ({1'b0, bytes_done} + 33'(PAGE_BYTES) > 33'hFFFFFFFF) ?
              32'hFFFFFFFF : bytes_done + 32'(PAGE_BYTES);
            write_address <= write_address + 32'(PAGE_BYTES);
            stat.done_img <= (({1'b0, bytes_done} + 33'(PAGE_BYTES) > 33'hFFFFFFFF) ?
              32'hFFFFFFFF : bytes_done + 32'(PAGE_BYTES)) >= image_size;
          end
          stat.sum_ok <= (data_sum + sum_exp) == 32'd0;
        end
        C_RESP: res <= '{K_RESP, 32'd0, 32'd0, 8'd0, cmd.code,
                         crc8(crc8(CRC_INIT, {5'd0, cmd.code}), 8'd0), cmd.last};
        C_TAIL_MAGIC: res <= '{K_WRITE, flash_base, image_magic, 8'd0, RC_OK, 16'd0,
                               cmd.last};
        C_TAIL_SIZE: res <= '{K_WRITE, flash_base + 32'd4, image_size, 8'd0, RC_OK,
                              16'd0, cmd.last};
        C_TAIL_SUM: res <= '{K_WRITE, flash_base + 32'd8, 32'd0 - data_sum, 8'd0,
                             RC_OK, 16'd0, cmd.last};
        default: ;
      endcase
    end
  end

  // page store read port, registered
  assign rd_next = (cmd.op == C_WORD) ? rd_i + WIW'(1) : rd_i;

  always_ff @(posedge clk) begin
    rd_data <= page_store[rd_next[AW-1:0]];
  end
endmodule

@@ src/cir_ctrl.sv @@
// Controller: sequences byte handling, page emission, verify and responses.
module cir_ctrl (
  input  logic             clk,
  input  logic             rst,
  cir_if.sink              in_ch,
  input  cir_pkg::stat_t   stat,
  output cir_pkg::cmd_t    cmd,
  output logic             res_valid,
  input  logic             res_ready
);
  import cir_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_FIN = 4'd2, S_FIN2 = 4'd3,
    S_ERASE = 4'd4, S_WORD = 4'd5, S_PEND = 4'd6, S_VER = 4'd7, S_VCHK = 4'd8,
    S_TAIL = 4'd9, S_HALT = 4'd10, S_OUT = 4'd11, S_WAITV = 4'd12;
  logic [3:0] state, ret;
  logic [1:0] tail;
  logic held;
  logic vfail;
  logic res_cmd;

  assign in_ch.ready = (state == S_IDLE || state == S_WAITV || state == S_HALT) && !held;

  // the datapath loads the result register on the edge that runs these commands
  assign res_cmd = (cmd.op == C_ERASE) || (cmd.op == C_WORD) || (cmd.op == C_PEND) ||
                   (cmd.op == C_RESP) || (cmd.op == C_TAIL_MAGIC) ||
                   (cmd.op == C_TAIL_SIZE) || (cmd.op == C_TAIL_SUM);

  // state sequencing and output stage: one result held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ret <= S_IDLE; held <= 1'b0; tail <= '0; vfail <= 1'b0;
      cmd <= '{C_NONE, RC_OK, 1'b0};
    end else begin
      cmd <= '{C_NONE, RC_OK, 1'b0};
      if (res_cmd) held <= 1'b1;
      else if (held && res_ready) held <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && !held && in_ch.data.req_type == 1'b0) begin
          cmd <= '{C_BYTE, RC_OK, 1'b0}; state <= S_CHK;
        end
        S_CHK: if (cmd.op == C_NONE) begin
          if (stat.fail) begin
            cmd <= '{C_RESP, stat.fail_code, 1'b1}; state <= S_HALT;
          end else if (stat.finish) begin
            cmd <= '{C_FIN_START, RC_OK, 1'b0}; state <= S_FIN;
          end else state <= S_IDLE;
        end
        S_FIN: state <= S_FIN2;
        S_FIN2: if (stat.fail) begin
          cmd <= '{C_RESP, RC_CRC, 1'b1}; state <= S_HALT;
        end else state <= stat.erase_due ? S_ERASE : S_WORD;
        S_ERASE: if (!held) begin
          cmd <= '{C_ERASE, RC_OK, 1'b0}; state <= S_OUT; ret <= S_WORD;
        end
        S_WORD: if (!held) begin
          if (stat.word_more) begin
            cmd <= '{C_WORD, RC_OK, 1'b0}; state <= S_OUT; ret <= S_WORD;
          end else begin
            cmd <= '{C_PEND, RC_OK, 1'b1}; state <= S_OUT; ret <= S_WAITV;
          end
        end
        S_OUT: state <= ret;
        S_WAITV: if (in_ch.valid && !held && in_ch.data.req_type == 1'b1) begin
          if (!in_ch.data.verify_ok) begin
            cmd <= '{C_RESP, RC_VER, 1'b1}; state <= S_HALT;
          end else begin
            cmd <= '{C_VERIFY, RC_OK, 1'b0}; state <= S_VER;
          end
        end
        S_VER: state <= S_VCHK;
        S_VCHK: begin
          if (stat.done_img && !stat.sum_ok) begin
            cmd <= '{C_RESP, RC_OK, 1'b0}; vfail <= 1'b1;
            state <= S_OUT; ret <= S_TAIL;
          end else begin
            cmd <= '{C_RESP, RC_OK, !stat.done_img};
            state <= S_OUT; ret <= stat.done_img ? S_TAIL : S_IDLE;
          end
          tail <= '0;
        end
        S_TAIL: if (!held) begin
          if (vfail) begin
            cmd <= '{C_RESP, RC_SUM, 1'b1}; state <= S_HALT;
          end else begin
            unique case (tail)
              2'd0: cmd <= '{C_TAIL_MAGIC, RC_OK, 1'b0};
              2'd1: cmd <= '{C_TAIL_SIZE, RC_OK, 1'b0};
              default: cmd <= '{C_TAIL_SUM, RC_OK, 1'b1};
            endcase
            tail <= tail + 2'd1;
            state <= (tail == 2'd2) ? S_HALT : S_OUT; ret <= S_TAIL;
          end
        end
        default: ;
      endcase
    end
  end
  assign res_valid = held;

  // a waiting result stays valid until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    held && !res_ready |=> held) else $error("held item dropped");
  // no item taken while a result from an earlier one still waits
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    held |-> !in_ch.ready) else $error("accept while busy");
  // halt is final
  a_halt: assert property (@(posedge clk) disable iff (rst)
    state == S_HALT && !held |=> state == S_HALT) else $error("left halt");
endmodule

@@ src/chunked_image_receiver.sv @@
// Top level: chunked image receiver.
// Takes one link byte or verify report per item. A byte item passes through
// the controller as accept, datapath step and status check; the byte ending
// a chunk then issues the chunk's results, each issued once the previous
// result has been taken (command, result valid, handshake), so a full first
// page gives an erase, 29 words and a page end. Only one item is in flight:
// the next is accepted when the previous item's results are all taken. No
// reset sweep is needed; the page store is always written before read.
module chunked_image_receiver #(
  parameter int PAGE_BYTES = cir_pkg::PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = cir_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  cir_if.sink         in_ch,
  cir_if.source       out_ch
);
  import cir_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  out_item_t res;
  in_item_t  item_q;

  // accepted input item, held for the datapath's byte step
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q <= '0;
    end else if (in_ch.valid && in_ch.ready) begin
      item_q <= in_ch.data;
    end
  end

  cir_ctrl u_ctrl (.clk, .rst, .in_ch, .stat, .cmd, .res_valid(out_ch.valid),
                   .res_ready(out_ch.ready));
  cir_datapath #(.PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .item(item_q), .cmd, .stat, .res);
  assign out_ch.data = res;
endmodule
